// ===== hdl/tcpq_pkg.sv =====
package tcpq_pkg;

	localparam int DEPTH         = 16;
	localparam int PAYLOAD_WIDTH = 32;
	localparam int ADDR_W        = $clog2(DEPTH);
	localparam int CNT_W         = $clog2(DEPTH + 1);

	// fixed port widths
	localparam int MODE_W   = 2;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;
	localparam int TOTAL_W  = 6;

	localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DEQ = 2'd1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic                     wr_en;
		logic                     wr_high;
		logic [ADDR_W-1:0]        wr_addr;
		logic [PAYLOAD_WIDTH-1:0] wr_data;
		logic                     rd_en;
		logic                     rd_high;
		logic [ADDR_W-1:0]        rd_front;
		logic [ADDR_W-1:0]        rd_back;
	} tcpq_mem_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                serving_high;
		logic                empty;
		logic [CNT_W-1:0]    high_fill;
		logic [CNT_W-1:0]    low_fill;
	} tcpq_meta_t;

	// ring index wrap; sum is below 2*DEPTH, but for the don't-care back index of an empty FIFO
	function automatic logic [ADDR_W-1:0] ring_wrap(input logic [CNT_W:0] sum);
		logic [CNT_W:0] lim;
		lim = (CNT_W + 1)'(DEPTH);
		if (sum >= lim)
			return ADDR_W'(sum - lim);
		else
			return ADDR_W'(sum);
	endfunction

endpackage

// ===== hdl/tcpq_store.sv =====
module tcpq_store import tcpq_pkg::*; (
	input  logic                     clk,
	input  tcpq_mem_req_t            req,
	output logic [PAYLOAD_WIDTH-1:0] front_data,
	output logic [PAYLOAD_WIDTH-1:0] back_data
);

	logic [PAYLOAD_WIDTH-1:0] hi_mem [DEPTH];
	logic [PAYLOAD_WIDTH-1:0] lo_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en && req.wr_high)
			hi_mem[req.wr_addr] <= req.wr_data;
		if (req.wr_en && !req.wr_high)
			lo_mem[req.wr_addr] <= req.wr_data;
	end

	// two read ports, registered
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			front_data <= req.rd_high ? hi_mem[req.rd_front] : lo_mem[req.rd_front];
			back_data  <= req.rd_high ? hi_mem[req.rd_back]  : lo_mem[req.rd_back];
		end
	end

endmodule

// ===== hdl/tcpq_ctrl.sv =====
module tcpq_ctrl import tcpq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [MODE_W-1:0]   mode,
	input  logic                high_class,
	input  logic [WORD_W-1:0]   item_payload,
	input  logic                out_free,
	output logic                rsp_pending,
	output tcpq_meta_t          meta,
	output tcpq_mem_req_t       mem_req
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0]          state_q;
	logic [ADDR_W-1:0]   hi_head_q, lo_head_q;
	logic [CNT_W-1:0]    hi_fill_q, lo_fill_q;
	logic [STATUS_W-1:0] status_q;

	logic                accept;
	logic [ADDR_W-1:0]   sel_head, srv_head;
	logic [CNT_W-1:0]    sel_fill, srv_fill;
	logic                sel_full, serving_high;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	assign sel_head = high_class ? hi_head_q : lo_head_q;
	assign sel_fill = high_class ? hi_fill_q : lo_fill_q;
	assign sel_full = (sel_fill == CNT_W'(DEPTH));

	assign serving_high = (hi_fill_q != '0);
	assign srv_head     = serving_high ? hi_head_q : lo_head_q;
	assign srv_fill     = serving_high ? hi_fill_q : lo_fill_q;

	always_comb begin
		mem_req          = '0;
		mem_req.wr_en    = accept && (mode == MODE_ENQ) && !sel_full;
		mem_req.wr_high  = high_class;
		mem_req.wr_addr  = ring_wrap((CNT_W + 1)'(sel_head) + (CNT_W + 1)'(sel_fill));
		mem_req.wr_data  = item_payload[PAYLOAD_WIDTH-1:0];
		mem_req.rd_en    = (state_q == S_READ);
		mem_req.rd_high  = serving_high;
		mem_req.rd_front = srv_head;
		// back index is don't-care when the serving FIFO is empty
		mem_req.rd_back  = ring_wrap((CNT_W + 1)'(srv_head) + (CNT_W + 1)'(srv_fill)
			- (CNT_W + 1)'(1));
	end

	assign meta.status       = status_q;
	assign meta.serving_high = serving_high;
	assign meta.empty        = (srv_fill == '0);
	assign meta.high_fill    = hi_fill_q;
	assign meta.low_fill     = lo_fill_q;
	assign rsp_pending       = (state_q == S_RESP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			hi_head_q <= '0;
			lo_head_q <= '0;
			hi_fill_q <= '0;
			lo_fill_q <= '0;
			status_q  <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= ST_OK;
						state_q  <= S_READ;
						case (mode)
							MODE_ENQ: begin
								if (sel_full)
									status_q <= ST_FULL;
								else if (high_class)
									hi_fill_q <= hi_fill_q + CNT_W'(1);
								else
									lo_fill_q <= lo_fill_q + CNT_W'(1);
							end
							MODE_DEQ: begin
								if (hi_fill_q != '0) begin
									hi_head_q <= ring_wrap((CNT_W + 1)'(hi_head_q) + (CNT_W + 1)'(1));
									hi_fill_q <= hi_fill_q - CNT_W'(1);
								end else if (lo_fill_q != '0) begin
									lo_head_q <= ring_wrap((CNT_W + 1)'(lo_head_q) + (CNT_W + 1)'(1));
									lo_fill_q <= lo_fill_q - CNT_W'(1);
								end else begin
									status_q <= ST_EMPTY;
								end
							end
							default: ;
						endcase
					end
				end
				S_READ: state_q <= S_RESP;
				S_RESP: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/two_class_priority_queue_unit.sv =====
// Two-class strict priority queue, one result beat per input beat.
// Each input beat passes through the write/pointer update, the registered memory
// read of the store and the result load into the output register; a new input
// beat is taken only once the last one has been loaded into the output register.
// Reset (arst_n low, asynchronous): both FIFOs empty, heads zero, no result
// pending; store contents stay undefined, and unwritten entries are never reported.
module two_class_priority_queue_unit import tcpq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [MODE_W-1:0]   mode,
	input  logic                high_class,
	input  logic [WORD_W-1:0]   item_payload,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [WORD_W-1:0]   front_payload,
	output logic                serving_high,
	output logic [WORD_W-1:0]   back_payload,
	output logic [COUNT_W-1:0]  high_count,
	output logic [COUNT_W-1:0]  low_count,
	output logic [TOTAL_W-1:0]  total_count,
	output logic                all_empty
);

	tcpq_mem_req_t            mem_req;
	tcpq_meta_t               meta;
	logic                     rsp_pending;
	logic                     out_free;
	logic                     load;
	logic [PAYLOAD_WIDTH-1:0] front_data, back_data;

	// The controller writes the store in the accept cycle and reads it the
	// cycle after, so a read never meets a write in flight: no bypass needed.
	tcpq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.high_class   (high_class),
		.item_payload (item_payload),
		.out_free     (out_free),
		.rsp_pending  (rsp_pending),
		.meta         (meta),
		.mem_req      (mem_req)
	);

	tcpq_store u_store (
		.clk        (clk),
		.req        (mem_req),
		.front_data (front_data),
		.back_data  (back_data)
	);

	// Output register: the result beat waits here while the controller is
	// free to take the next input beat.
	assign out_free = !out_valid || out_ready;
	assign load     = rsp_pending && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (out_free)
			out_valid <= rsp_pending;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status        <= meta.status;
			serving_high  <= meta.serving_high;
			all_empty     <= meta.empty;
			// front and back read as zero when nothing is held
			front_payload <= meta.empty ? '0 : WORD_W'(front_data);
			back_payload  <= meta.empty ? '0 : WORD_W'(back_data);
			// counts are reported modulo their field widths
			high_count    <= COUNT_W'(meta.high_fill);
			low_count     <= COUNT_W'(meta.low_fill);
			total_count   <= TOTAL_W'(meta.high_fill) + TOTAL_W'(meta.low_fill);
		end
	end

endmodule

// ===== hdl/tcpq_checker.sv =====
module tcpq_checker import tcpq_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [STATUS_W-1:0] status,
	input logic [WORD_W-1:0]   front_payload,
	input logic                serving_high,
	input logic [WORD_W-1:0]   back_payload,
	input logic [TOTAL_W-1:0]  total_count,
	input logic                all_empty
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(front_payload)
			&& $stable(back_payload) && $stable(total_count))
		else $error("result beat changed while stalled");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (all_empty == (total_count == '0)))
		else $error("empty flag disagrees with total count");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && all_empty |-> front_payload == '0 && back_payload == '0 && !serving_high)
		else $error("empty queue reports data");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while previous beat in progress");

endmodule

bind two_class_priority_queue_unit tcpq_checker u_tcpq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.front_payload (front_payload),
	.serving_high  (serving_high),
	.back_payload  (back_payload),
	.total_count   (total_count),
	.all_empty     (all_empty)
);
